### hdl/oneshot_delay_timer_pool_defines.svh
// Assertion macros of the timer pool RTL.
`ifndef ONESHOT_DELAY_TIMER_POOL_DEFINES_SVH
`define ONESHOT_DELAY_TIMER_POOL_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ODTP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("timer pool: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ODTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("timer pool: next-cycle check failed");

`else

`define ODTP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ODTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/odtp_pkg.sv
// Shared types and constants of the one-shot delay timer pool.
package odtp_pkg;

    localparam int DEF_CHANNELS = 4;
    localparam int DEF_TAG_BITS = 8;

    localparam int DELAY_W = 16;
    localparam int TAG_W   = 8;
    localparam int KIND_W  = 2;
    localparam int CHAN_W  = 2;

    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    localparam logic [KIND_W-1:0] K_ACCEPTED = 2'd0;
    localparam logic [KIND_W-1:0] K_NO_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] K_EXPIRED  = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [DELAY_W-1:0] delay_us;
        logic [TAG_W-1:0]   tag;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] channel;
        logic [TAG_W-1:0]  handle;
        logic              last;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic alloc;
        logic scan;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
    } t_dp_stat;

endpackage

### hdl/odtp_ctrl.sv
// Controller state machine of the one-shot delay timer pool.
module odtp_ctrl
    import odtp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_mode,
    input  t_dp_stat i_stat,
    output logic     o_busy,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ALLOC = 3'b010,
        S_SCAN  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_mode == MODE_REQUEST) ? S_ALLOC : S_SCAN;
                end
            end
            S_ALLOC: begin
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_cmd.capture = i_start && (r_state == S_IDLE);
    assign o_cmd.alloc   = (r_state == S_ALLOC);
    assign o_cmd.scan    = (r_state == S_SCAN);

endmodule

### hdl/odtp_datapath.sv
// Datapath of the one-shot delay timer pool: counter, channel store, scan and result.
`include "oneshot_delay_timer_pool_defines.svh"

module odtp_datapath
    import odtp_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS,
    parameter int TAG_BITS = DEF_TAG_BITS
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_item i_item,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output logic     o_strobe,
    output t_result  o_result
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [DELAY_W-1:0]  r_count;
    logic [DELAY_W-1:0]  n_count;
    logic [DELAY_W-1:0]  r_cmp [CHANNELS];
    logic [TAG_BITS-1:0] r_tag [CHANNELS];
    logic [CHANNELS-1:0] r_pend;
    logic [CHANNELS-1:0] n_pend;
    logic [CHANNELS-1:0] r_hit;
    logic [CHANNELS-1:0] n_hit;
    logic [CH_W-1:0]     r_idx;
    logic [CH_W-1:0]     n_idx;
    logic [DELAY_W-1:0]  r_delay;
    logic [TAG_BITS-1:0] r_req_tag;
    logic                r_strobe;
    logic                n_strobe;
    t_result             r_result;
    t_result             n_result;

    logic [DELAY_W-1:0]  w_next_count;
    logic [CHANNELS-1:0] w_hit;
    logic [CHANNELS-1:0] w_rest;
    logic [CH_W-1:0]     w_free_idx;
    logic                w_free_any;

    assign w_next_count = r_count + 16'd1;
    assign w_free_any   = (r_pend != {CHANNELS{1'b1}});

    // Match every pending channel against the count the tick will produce.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_hit[c] = r_pend[c] && (r_cmp[c] == w_next_count);
        end
    end

    // Lowest idle channel.
    always_comb begin
        w_free_idx = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (!r_pend[c]) begin
                w_free_idx = CH_W'(c);
            end
        end
    end

    // Hits still to report once the current channel is done.
    always_comb begin
        w_rest        = r_hit;
        w_rest[r_idx] = 1'b0;
    end

    assign o_stat.scan_done = (w_rest == '0);

    always_comb begin
        n_count  = r_count;
        n_pend   = r_pend;
        n_hit    = r_hit;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_result = r_result;
        if (i_cmd.capture && (i_item.mode == MODE_TICK)) begin
            n_count = w_next_count;
            n_hit   = w_hit;
            n_idx   = '0;
        end
        if (i_cmd.alloc) begin
            n_strobe = 1'b1;
            if (w_free_any) begin
                n_pend[w_free_idx] = 1'b1;
                n_result = '{kind: K_ACCEPTED, channel: CHAN_W'(w_free_idx),
                             handle: TAG_W'(r_req_tag), last: 1'b1};
            end else begin
                n_result = '{kind: K_NO_FREE, channel: '0,
                             handle: TAG_W'(r_req_tag), last: 1'b1};
            end
        end
        if (i_cmd.scan) begin
            n_idx = r_idx + CH_W'(1);
            if (r_hit[r_idx]) begin
                n_strobe      = 1'b1;
                n_pend[r_idx] = 1'b0;
                n_hit         = w_rest;
                n_result = '{kind: K_EXPIRED, channel: CHAN_W'(r_idx),
                             handle: TAG_W'(r_tag[r_idx]), last: (w_rest == '0)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend   <= '0;
            r_hit    <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_hit    <= n_hit;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    // Payload: request fields, channel store and result.
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (i_cmd.capture) begin
            r_delay   <= i_item.delay_us;
            r_req_tag <= TAG_BITS'(i_item.tag);
        end
        if (i_cmd.alloc && w_free_any) begin
            r_cmp[w_free_idx] <= r_count + r_delay;
            r_tag[w_free_idx] <= r_req_tag;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `ODTP_ASSERT_NEXT(a_alloc_takes_one, i_clk, i_rst_n, i_cmd.alloc && w_free_any, $countones(r_pend) == $past($countones(r_pend)) + 1)
    `ODTP_ASSERT_NEXT(a_expiry_frees_one, i_clk, i_rst_n, i_cmd.scan && r_hit[r_idx], $countones(r_pend) + 1 == $past($countones(r_pend)))
    `ODTP_ASSERT_IMPLY(a_request_result_last, i_clk, i_rst_n, r_strobe && (r_result.kind != K_EXPIRED), r_result.last)

endmodule

### hdl/oneshot_delay_timer_pool.sv
// Top level of the one-shot delay timer pool.
//
// A pool of CHANNELS one-shot delay channels that share a single 16-bit
// tick counter. An item is taken when start is high and busy is low. A request
// item (mode 1) grabs the lowest idle channel, arms it to expire delay_us ticks
// later (a delay of zero expires after a full wrap of 65536 ticks) and reports
// the channel with the tag; with every channel busy it reports "no free
// channel" and changes nothing. A tick item (mode 0) advances the counter and
// reports every channel that expires on the new count, lowest channel first,
// each freeing itself and returning its stored tag; a tick with no expiry gives
// no result. The final result of an item carries last. Results appear on
// o_result for exactly one cycle, marked by o_strobe, and cannot be held off:
// the receiver must take them as they come. A request raises busy while it
// allocates and shows its result in the cycle after; no new item is taken
// while it allocates. A tick raises busy while the expiry scan walks the
// channel store one entry per cycle from channel 0 up to the highest expiring
// channel, visiting channel 0 alone when at most channel 0 expires; no new
// item is taken until the scan ends. Each expiry shows in the cycle after its
// channel is visited. Reset is synchronous, active low, and leaves every
// channel idle with the counter at zero.
module oneshot_delay_timer_pool
    import odtp_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS,
    parameter int TAG_BITS = DEF_TAG_BITS
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_in_item i_item,
    output logic     o_strobe,
    output t_result  o_result
);

    // Command and status between the sequencer and the datapath.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer: idle, allocate a channel, or walk the expiry scan.
    odtp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_item.mode),
        .i_stat  (w_stat),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    // Counter, channel store, compare and result register.
    odtp_datapath #(
        .CHANNELS (CHANNELS),
        .TAG_BITS (TAG_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
